>>> rtl/core/bpk_pkg.sv
// Shared types and constants for the MSB-first bit packer.
package bpk_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned BITS_W     = 6;
   localparam int unsigned PEND_W     = 7;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [2:0] INDEX_MASK = 3'h7;
   localparam logic [7:0] TOP_BIT    = 8'h80;

   typedef enum logic {
      FUNC_PUSH  = 1'b0,
      FUNC_FLUSH = 1'b1
   } func_type;

   typedef struct packed {
      logic byte_valid;
      logic last;
   } rsp_flags_type;

endpackage

>>> rtl/core/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: input register, datapath, result buffer.
//
// Usage:
//   req channel: one item per transfer. req_tuser selects push (0) or flush (1).
//   A push appends the low field_bits bits of field_value, most significant bit
//   first; counts above the field limit saturate, a count of 0 changes nothing.
//   rsp channel: one stream byte per transfer, earliest bit in bit 7. A flush
//   gives one result with rsp_tlast high: the padded partial byte, or an empty
//   marker (rsp_tuser low) when no bits are held, plus the total bit count,
//   and then clears all held state.
//   An item passes the input register and then the result buffer before its
//   first result is offered on rsp.
//   Throughput: an item holds the result buffer until its result bytes, 0 to
//   4 (4 for a 32-bit push), have drained, one byte per rsp transfer; pushes
//   without a result pass at one per cycle unless an earlier item waits.
//   Reset clears the held bits, the bit total, in_vld_ff and the byte count.
//   A stall on rsp holds the current byte; the input register keeps taking
//   one item and then holds req_tready low until the buffer frees.
module msb_first_bit_packer #(
   parameter int unsigned MAX_FIELD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] field_value, [37:32] field_bits, [39:38] zero
   input  logic [bpk_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] out_byte, [39:8] total_bits
   output logic [bpk_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] byte_valid
   output logic                               rsp_tuser,
   // last
   output logic                               rsp_tlast
);

   localparam int unsigned LIMIT     = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
   localparam int unsigned MAX_BYTES = (bpk_pkg::PEND_W + LIMIT) / bpk_pkg::BYTE_W;
   localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

   logic                           in_vld_ff;
   bpk_pkg::func_type              func_ff;
   logic [bpk_pkg::VALUE_W-1:0]    value_ff;
   logic [bpk_pkg::BITS_W-1:0]     bits_ff;

   logic                           take;
   logic                           load_ok;
   logic [MAX_BYTES-1:0][7:0]      res_bytes;
   logic [CNT_W-1:0]               res_count;
   bpk_pkg::rsp_flags_type         res_flags;
   logic [bpk_pkg::TOTAL_W-1:0]    res_total;

   assign req_tready = !in_vld_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         func_ff  <= bpk_pkg::func_type'(req_tuser);
         value_ff <= req_tdata[bpk_pkg::VALUE_W-1:0];
         bits_ff  <= req_tdata[bpk_pkg::VALUE_W +: bpk_pkg::BITS_W];
      end
   end

   bpk_core #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_vld_ff),
      .item_func  (func_ff),
      .item_value (value_ff),
      .item_bits  (bits_ff),
      .load_ok    (load_ok),
      .take       (take),
      .res_bytes  (res_bytes),
      .res_count  (res_count),
      .res_flags  (res_flags),
      .res_total  (res_total)
   );

   bpk_rsp_buf #(
      .MAX_BYTES (MAX_BYTES)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (take && (res_count != '0)),
      .load_bytes (res_bytes),
      .load_count (res_count),
      .load_flags (res_flags),
      .load_total (res_total),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/core/bpk_core.sv
// Packing datapath: held-bit state, byte extraction and flush handling.
module bpk_core #(
   parameter int unsigned MAX_FIELD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_valid,
   input  bpk_pkg::func_type                       item_func,
   input  logic [bpk_pkg::VALUE_W-1:0]             item_value,
   input  logic [bpk_pkg::BITS_W-1:0]              item_bits,
   input  logic                                    load_ok,
   output logic                                    take,
   output logic [((7+((MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32))/8)-1:0][7:0] res_bytes,
   output logic [$clog2(((7+((MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32))/8)+1)-1:0]
                                                   res_count,
   output bpk_pkg::rsp_flags_type                  res_flags,
   output logic [bpk_pkg::TOTAL_W-1:0]             res_total
);

   localparam int unsigned LIMIT     = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
   localparam int unsigned ACC_W     = bpk_pkg::PEND_W + LIMIT;
   localparam int unsigned MAX_BYTES = ACC_W / bpk_pkg::BYTE_W;
   localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int unsigned HAVE_W    = $clog2(ACC_W + 1);

   logic [bpk_pkg::PEND_W-1:0]  pend_ff, pend_in;
   logic [2:0]                  pcnt_ff, pcnt_in;
   logic [bpk_pkg::TOTAL_W-1:0] total_ff, total_in;

   logic [bpk_pkg::BITS_W-1:0]  n;
   logic [bpk_pkg::VALUE_W-1:0] masked;
   logic [ACC_W-1:0]            acc;
   logic [ACC_W-1:0]            left;
   logic [HAVE_W-1:0]           have;
   logic [2:0]                  pcnt_new;
   logic [bpk_pkg::BYTE_W-1:0]  flush_byte;

   always_comb begin
      // saturate oversized counts
      n = (item_bits > bpk_pkg::BITS_W'(LIMIT)) ? bpk_pkg::BITS_W'(LIMIT) : item_bits;
      masked   = item_value & ~({bpk_pkg::VALUE_W{1'b1}} << n);
      acc      = (ACC_W'(pend_ff) << n) | ACC_W'(masked[LIMIT-1:0]);
      have     = HAVE_W'(pcnt_ff) + HAVE_W'(n);
      // left-align the valid bits so byte j sits at a fixed place
      left     = acc << (HAVE_W'(ACC_W) - have);
      pcnt_new = have[2:0] & bpk_pkg::INDEX_MASK;
      flush_byte = bpk_pkg::BYTE_W'({1'b0, pend_ff} << (4'd8 - {1'b0, pcnt_ff}));

      res_bytes = '0;
      if (item_func == bpk_pkg::FUNC_FLUSH) begin
         res_bytes[0]         = flush_byte;
         res_count            = CNT_W'(1);
         res_flags.byte_valid = (pcnt_ff != 3'd0);
         res_flags.last       = 1'b1;
         res_total            = total_ff;
         pend_in              = '0;
         pcnt_in              = '0;
         total_in             = '0;
      end else begin
         for (int j = 0; j < MAX_BYTES; j++) begin
            res_bytes[j] = left[ACC_W-1-8*j -: 8];
         end
         res_count            = CNT_W'(have >> 3);
         res_flags.byte_valid = 1'b1;
         res_flags.last       = 1'b0;
         res_total            = '0;
         pend_in  = acc[bpk_pkg::PEND_W-1:0]
                  & ~({bpk_pkg::PEND_W{1'b1}} << pcnt_new)
                  & bpk_pkg::PEND_W'(bpk_pkg::TOP_BIT - 8'd1);
         pcnt_in  = pcnt_new;
         total_in = total_ff + bpk_pkg::TOTAL_W'(n);
      end

      // items without results never wait for the buffer
      take = item_valid && ((res_count == '0) || load_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         pcnt_ff  <= '0;
         total_ff <= '0;
      end else if (take) begin
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         total_ff <= total_in;
      end
   end

endmodule

>>> rtl/core/bpk_rsp_buf.sv
// Result buffer: holds the bytes of one item and drains them one per transfer.
module bpk_rsp_buf #(
   parameter int unsigned MAX_BYTES = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [MAX_BYTES-1:0][7:0]             load_bytes,
   input  logic [$clog2(MAX_BYTES+1)-1:0]        load_count,
   input  bpk_pkg::rsp_flags_type                load_flags,
   input  logic [bpk_pkg::TOTAL_W-1:0]           load_total,
   output logic                                  load_ok,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bpk_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);

   logic [MAX_BYTES-1:0][7:0]    bytes_ff;
   logic [CNT_W-1:0]             left_ff;
   bpk_pkg::rsp_flags_type       flags_ff;
   logic [bpk_pkg::TOTAL_W-1:0]  total_ff;
   logic                         pop;

   assign pop     = (left_ff != '0) && rsp_tready;
   assign load_ok = (left_ff == '0) || ((left_ff == CNT_W'(1)) && rsp_tready);

   assign rsp_tvalid = (left_ff != '0);
   assign rsp_tdata  = {total_ff, bytes_ff[0]};
   assign rsp_tuser  = flags_ff.byte_valid;
   assign rsp_tlast  = flags_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (load) begin
         left_ff <= load_count;
      end else if (pop) begin
         left_ff <= left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= load_bytes;
         flags_ff <= load_flags;
         total_ff <= load_total;
      end else if (pop) begin
         // advance to the next byte of the item
         for (int j = 0; j < MAX_BYTES - 1; j++) begin
            bytes_ff[j] <= bytes_ff[j+1];
         end
      end
   end

endmodule

>>> dv/msb_first_bit_packer_test.sv
// Self-checking testbench for the MSB-first bit packer: directed and random field streams.
module msb_first_bit_packer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIELD_LIMIT = 32;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 80;

   typedef struct packed {
      logic [bpk_pkg::BYTE_W-1:0]  out_byte;
      logic                        byte_valid;
      logic                        is_last;
      logic [bpk_pkg::TOTAL_W-1:0] total_bits;
   } stream_byte_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bpk_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bpk_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;

   // Predictor state
   logic [bpk_pkg::PEND_W-1:0]  held_bits = '0;
   logic [2:0]                  held_count = '0;
   logic [bpk_pkg::TOTAL_W-1:0] pushed_total = '0;

   stream_byte_type expected_bytes[$];
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     burst_left = 0;
   logic [7:0]      stall_phase = '0;

   msb_first_bit_packer #(
      .MAX_FIELD_BITS(FIELD_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("msb_first_bit_packer_test: FAIL");
         $finish;
      end
   end

   // Append one expected result at the tail of the queue.
   task automatic note_expected(stream_byte_type r);
      begin
         expected_bytes = {expected_bytes, r};
      end
   endtask

   // Work out the bytes one accepted item emits and update the held state.
   task automatic pack_expected(bpk_pkg::func_type op, logic [bpk_pkg::VALUE_W-1:0] value,
                                logic [bpk_pkg::BITS_W-1:0] bits);
      int unsigned     n;
      int unsigned     have;
      logic [63:0]     acc;
      stream_byte_type res;
      begin
         if (op == bpk_pkg::FUNC_FLUSH) begin
            res.is_last = 1'b1;
            res.total_bits = pushed_total;
            if (held_count != 0) begin
               res.out_byte = 8'(({1'b0, held_bits} << (bpk_pkg::BYTE_W - held_count)));
               res.byte_valid = 1'b1;
            end else begin
               res.out_byte = '0;
               res.byte_valid = 1'b0;
            end
            note_expected(res);
            held_bits = '0;
            held_count = '0;
            pushed_total = '0;
         end else begin
            n = (bits > FIELD_LIMIT) ? FIELD_LIMIT : bits;
            if (n != 0) begin
               acc = ({57'b0, held_bits} << n) | (64'(value) & ((64'd1 << n) - 64'd1));
               have = held_count + n;
               while (have >= bpk_pkg::BYTE_W) begin
                  res.out_byte = 8'(acc >> (have - bpk_pkg::BYTE_W));
                  res.byte_valid = 1'b1;
                  res.is_last = 1'b0;
                  res.total_bits = '0;
                  note_expected(res);
                  have -= bpk_pkg::BYTE_W;
               end
               held_count = 3'(have);
               held_bits = 7'(acc & ((64'd1 << have) - 64'd1));
               pushed_total = pushed_total + bpk_pkg::TOTAL_W'(n);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pack_expected(bpk_pkg::func_type'(req_tuser), req_tdata[31:0], req_tdata[37:32]);
   end

   always @(posedge clock) begin
      stream_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected result transfer: out_byte %0h", rsp_tdata[7:0]);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== want.out_byte) begin
               $error("out_byte: expected %0h, actual %0h", want.out_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tuser !== want.byte_valid) begin
               $error("byte_valid: expected %0b, actual %0b", want.byte_valid, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last: expected %0b, actual %0b", want.is_last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[39:8] !== want.total_bits) begin
               $error("total_bits: expected %0h, actual %0h", want.total_bits,
                      rsp_tdata[39:8]);
               error_count++;
            end
         end
      end
   end

   // Receiver: cycle through always-ready, light, periodic and heavy stalls.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      unique case (stall_phase[7:6])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_phase[2:0] >= 3'd3);
         2'd3: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   task automatic send_transfer(bpk_pkg::func_type op, logic [bpk_pkg::VALUE_W-1:0] value,
                                logic [bpk_pkg::BITS_W-1:0] bits);
      begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
         end
         req_tvalid <= 1'b1;
         req_tuser <= op;
         req_tdata <= {2'b00, bits, value};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left--;
      end
   endtask

   // Hold off the sender until every expected byte has come out.
   task automatic drain_results();
      begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         @(posedge clock);
         while (expected_bytes.size() != 0) @(posedge clock);
         repeat (8) @(posedge clock);
      end
   endtask

   task automatic test_directed();
      begin
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 6'd0);
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'h0, 6'd0);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_0001, 6'd1);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hFFFF_FF55, 6'd7);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_0005, 6'd3);
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'h0, 6'd0);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_00A5, 6'd8);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 6'd32);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_0000, 6'd32);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 6'd33);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hDEAD_BEEF, 6'd63);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_0013, 6'd5);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h1234_5678, 6'd32);
         // flush ignores its operands, with and without held bits
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 6'd63);
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'hFFFF_FFFF, 6'd63);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_007F, 6'd7);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hCAFE_F00D, 6'd32);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 6'd0);
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'h0, 6'd0);
         send_transfer(bpk_pkg::FUNC_PUSH, 32'h0000_0000, 6'd0);
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'h5555_5555, 6'd21);
         drain_results();
      end
   endtask

   function automatic logic [bpk_pkg::BITS_W-1:0] pick_field_bits();
      int unsigned r;
      begin
         r = $urandom_range(0, 9);
         if (r <= 6) return bpk_pkg::BITS_W'($urandom_range(1, 32));
         if (r == 7) return 6'd32;
         if (r == 8) return bpk_pkg::BITS_W'($urandom_range(33, 63));
         return 6'd0;
      end
   endfunction

   task automatic test_random_streams();
      int unsigned sent;
      int unsigned pushes;
      bit          drained;
      begin
         sent = 0;
         drained = 0;
         while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               pushes = $urandom_range(1, 6);
               repeat (pushes)
                  send_transfer(bpk_pkg::FUNC_PUSH, $urandom, pick_field_bits());
               send_transfer(bpk_pkg::FUNC_FLUSH, $urandom,
                             bpk_pkg::BITS_W'($urandom_range(0, 63)));
               sent += pushes + 1;
            end else if ($urandom_range(0, 1) == 0) begin
               send_transfer(bpk_pkg::FUNC_FLUSH, $urandom,
                             bpk_pkg::BITS_W'($urandom_range(0, 63)));
               sent++;
            end else begin
               // push without flush: leaves held bits for the next stream
               send_transfer(bpk_pkg::FUNC_PUSH, $urandom, pick_field_bits());
               sent++;
            end
            if (!drained && sent >= RANDOM_ITEMS / 2) begin
               drain_results();
               drained = 1;
            end
         end
         send_transfer(bpk_pkg::FUNC_FLUSH, 32'h0, 6'd0);
         drain_results();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_streams();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("msb_first_bit_packer_test: PASS");
      end else begin
         $display("msb_first_bit_packer_test: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/bpk_pkg.sv
rtl/core/bpk_core.sv
rtl/core/bpk_rsp_buf.sv
rtl/core/msb_first_bit_packer.sv
dv/msb_first_bit_packer_test.sv
